@@ hw/rtl/sd_spi_init_sequencer_macros.svh @@
// Assertion macros for the SD SPI init sequencer checker.
// Clocked on i_clk, disabled while i_rst_n is low; no other dependencies.
`ifndef SD_SPI_INIT_SEQUENCER_MACROS_SVH
`define SD_SPI_INIT_SEQUENCER_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define SDSI_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sdsi checker: property failed");

// consequent checked in the cycle after the antecedent
`define SDSI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sdsi checker: property failed");

`endif

@@ hw/rtl/sdsi_pkg.sv @@
// Shared types and constants for the SD SPI init sequencer.
// No dependencies.
`default_nettype none

package sdsi_pkg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POLL_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIM  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LEN  = 2'd3;

    localparam logic [2:0] ST_BUSY     = 3'd0;
    localparam logic [2:0] ST_OK       = 3'd1;
    localparam logic [2:0] ST_CMD0_ERR = 3'd2;
    localparam logic [2:0] ST_CMD8_ERR = 3'd3;
    localparam logic [2:0] ST_TIMEOUT  = 3'd4;

    typedef enum logic [3:0] {
        PH_NONE   = 4'd0,
        PH_WAKE   = 4'd1,
        PH_CMD0   = 4'd2,
        PH_CMD8   = 4'd3,
        PH_CMD55  = 4'd4,
        PH_ACMD41 = 4'd5,
        PH_CMD16  = 4'd6,
        PH_OK     = 4'd7,
        PH_F0     = 4'd8,
        PH_F8     = 4'd9,
        PH_FTO    = 4'd10
    } t_phase;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       cs_low;
        logic       finished;
        logic [2:0] status;
    } t_result;

endpackage

`default_nettype wire

@@ hw/rtl/sdsi_seq_core.sv @@
// Sequencer state, configuration registers and next-byte logic.
// Depends on sdsi_pkg.
`default_nettype none

module sdsi_seq_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire sdsi_pkg::t_cfg_wr i_cfg,
    input  wire logic             i_accept,
    input  wire logic             i_req_type,
    input  wire logic [7:0]       i_rx_byte,
    output sdsi_pkg::t_result     o_result
);

    logic [7:0]  r_idle_bytes;
    logic [3:0]  r_poll_limit;
    logic [19:0] r_retry_lim;
    logic [12:0] r_block_len;

    sdsi_pkg::t_phase r_phase, n_phase;
    logic [2:0]  r_frame_pos, n_frame_pos;
    logic [3:0]  r_poll_cnt,  n_poll_cnt;
    logic [19:0] r_retry_cnt, n_retry_cnt;
    logic [7:0]  r_idle_cnt,  n_idle_cnt;

    logic [7:0]  idle_lim;
    logic [3:0]  poll_lim;
    logic [19:0] retry_lim;

    function automatic logic [7:0] frame_byte(input sdsi_pkg::t_phase ph,
                                              input logic [2:0] pos,
                                              input logic [12:0] blen);
        logic [5:0]  cmd;
        logic [31:0] arg;
        logic [7:0]  crc;
        case (ph)
            sdsi_pkg::PH_CMD0: begin
                cmd = 6'd0;  arg = 32'h0000_0000; crc = 8'h95;
            end
            sdsi_pkg::PH_CMD8: begin
                cmd = 6'd8;  arg = 32'h0000_01AA; crc = 8'h87;
            end
            sdsi_pkg::PH_CMD55: begin
                cmd = 6'd55; arg = 32'h0000_0000; crc = 8'h65;
            end
            sdsi_pkg::PH_ACMD41: begin
                cmd = 6'd41; arg = 32'h4000_0000; crc = 8'h77;
            end
            default: begin
                cmd = 6'd16; arg = {19'd0, blen}; crc = 8'h00;
            end
        endcase
        case (pos)
            3'd0:    frame_byte = 8'hFF;
            3'd1:    frame_byte = 8'h40 | {2'b00, cmd};
            3'd2:    frame_byte = arg[31:24];
            3'd3:    frame_byte = arg[23:16];
            3'd4:    frame_byte = arg[15:8];
            3'd5:    frame_byte = arg[7:0];
            default: frame_byte = crc | 8'h01;
        endcase
    endfunction

    function automatic logic [2:0] end_status(input sdsi_pkg::t_phase ph);
        case (ph)
            sdsi_pkg::PH_OK:  end_status = sdsi_pkg::ST_OK;
            sdsi_pkg::PH_F0:  end_status = sdsi_pkg::ST_CMD0_ERR;
            sdsi_pkg::PH_F8:  end_status = sdsi_pkg::ST_CMD8_ERR;
            sdsi_pkg::PH_FTO: end_status = sdsi_pkg::ST_TIMEOUT;
            default:          end_status = sdsi_pkg::ST_BUSY;
        endcase
    endfunction

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_bytes <= 8'd10;
            r_poll_limit <= 4'd8;
            r_retry_lim  <= 20'd100000;
            r_block_len  <= 13'd512;
        end else if (i_cfg.we) begin
            case (i_cfg.index)
                sdsi_pkg::CFG_IDLE_BYTES: r_idle_bytes <= i_cfg.data[7:0];
                sdsi_pkg::CFG_POLL_LIMIT: r_poll_limit <= i_cfg.data[3:0];
                sdsi_pkg::CFG_RETRY_LIM:  r_retry_lim  <= i_cfg.data[19:0];
                sdsi_pkg::CFG_BLOCK_LEN:  r_block_len  <= i_cfg.data[12:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= sdsi_pkg::PH_NONE;
            r_frame_pos <= '0;
            r_poll_cnt  <= '0;
            r_retry_cnt <= '0;
            r_idle_cnt  <= '0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_frame_pos <= n_frame_pos;
            r_poll_cnt  <= n_poll_cnt;
            r_retry_cnt <= n_retry_cnt;
            r_idle_cnt  <= n_idle_cnt;
        end
    end

    // zero limits behave as one
    assign idle_lim  = (r_idle_bytes == 8'd0)  ? 8'd1  : r_idle_bytes;
    assign poll_lim  = (r_poll_limit == 4'd0)  ? 4'd1  : r_poll_limit;
    assign retry_lim = (r_retry_lim  == 20'd0) ? 20'd1 : r_retry_lim;

    always_comb begin
        n_phase     = r_phase;
        n_frame_pos = r_frame_pos;
        n_poll_cnt  = r_poll_cnt;
        n_retry_cnt = r_retry_cnt;
        n_idle_cnt  = r_idle_cnt;
        o_result.tx_byte  = 8'hFF;
        o_result.cs_low   = 1'b0;
        o_result.finished = 1'b0;
        o_result.status   = sdsi_pkg::ST_BUSY;

        if (!i_req_type) begin
            n_phase     = sdsi_pkg::PH_WAKE;
            n_frame_pos = '0;
            n_poll_cnt  = '0;
            n_retry_cnt = '0;
            n_idle_cnt  = 8'd1;
        end else begin
            case (r_phase)
                sdsi_pkg::PH_NONE: begin
                    o_result.finished = 1'b1;
                end
                sdsi_pkg::PH_OK, sdsi_pkg::PH_F0, sdsi_pkg::PH_F8, sdsi_pkg::PH_FTO: begin
                    o_result.finished = 1'b1;
                    o_result.cs_low   = (r_phase != sdsi_pkg::PH_OK);
                    o_result.status   = end_status(r_phase);
                end
                sdsi_pkg::PH_WAKE: begin
                    if (r_idle_cnt < idle_lim) begin
                        n_idle_cnt = r_idle_cnt + 8'd1;
                    end else begin
                        n_phase         = sdsi_pkg::PH_CMD0;
                        n_frame_pos     = 3'd1;
                        n_poll_cnt      = '0;
                        o_result.cs_low = 1'b1;
                    end
                end
                default: begin
                    o_result.cs_low = 1'b1;
                    if (r_poll_cnt == 4'd0) begin
                        if (r_frame_pos != 3'd7) begin
                            o_result.tx_byte = frame_byte(r_phase, r_frame_pos, r_block_len);
                            n_frame_pos      = r_frame_pos + 3'd1;
                        end else begin
                            n_poll_cnt = 4'd1;
                        end
                    end else if (i_rx_byte[7] && (r_poll_cnt < poll_lim)) begin
                        n_poll_cnt = r_poll_cnt + 4'd1;
                    end else begin
                        // response resolved: either start the next command or end the run
                        n_frame_pos = 3'd1;
                        n_poll_cnt  = '0;
                        case (r_phase)
                            sdsi_pkg::PH_CMD0: begin
                                n_phase = (i_rx_byte == 8'h01) ? sdsi_pkg::PH_CMD8
                                                               : sdsi_pkg::PH_F0;
                            end
                            sdsi_pkg::PH_CMD8: begin
                                if (i_rx_byte == 8'h01) begin
                                    n_retry_cnt = 20'd1;
                                    n_phase     = sdsi_pkg::PH_CMD55;
                                end else begin
                                    n_phase = sdsi_pkg::PH_F8;
                                end
                            end
                            sdsi_pkg::PH_CMD55: begin
                                n_phase = sdsi_pkg::PH_ACMD41;
                            end
                            sdsi_pkg::PH_ACMD41: begin
                                if (i_rx_byte == 8'h00) begin
                                    n_phase = sdsi_pkg::PH_CMD16;
                                end else if (r_retry_cnt >= retry_lim) begin
                                    n_phase = sdsi_pkg::PH_FTO;
                                end else begin
                                    n_retry_cnt = r_retry_cnt + 20'd1;
                                    n_phase     = sdsi_pkg::PH_CMD55;
                                end
                            end
                            default: begin
                                n_phase = sdsi_pkg::PH_OK;
                            end
                        endcase
                        // end of run: chip-select released only on success
                        case (n_phase)
                            sdsi_pkg::PH_OK, sdsi_pkg::PH_F0, sdsi_pkg::PH_F8,
                            sdsi_pkg::PH_FTO: begin
                                n_frame_pos       = '0;
                                o_result.cs_low   = (n_phase != sdsi_pkg::PH_OK);
                                o_result.finished = 1'b1;
                                o_result.status   = end_status(n_phase);
                            end
                            default: ;
                        endcase
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/sdsi_out_reg.sv @@
// Result register with valid/ready handshake toward the byte engine.
// Depends on sdsi_pkg.
`default_nettype none

module sdsi_out_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire sdsi_pkg::t_result i_result,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output logic                   o_can_load,
    output sdsi_pkg::t_result      o_result
);

    logic              r_valid;
    sdsi_pkg::t_result r_result;

    // room when empty or when the held transaction drains this cycle
    assign o_can_load = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_result    = r_result;

endmodule

`default_nettype wire

@@ hw/rtl/sd_spi_init_sequencer.sv @@
// SD SPI init sequencer: result valid in the cycle after the transaction is accepted.
// Throughput 1 transaction per cycle; the only limit is the single result register,
// so input is taken whenever it is empty or being drained.
// Synchronous active-low reset: phase idle (not started), counters zero, result empty,
// registers 10 idle bytes, poll limit 8, retry limit 100000, block length 512.
// Top level; depends on sdsi_pkg, sdsi_seq_core, sdsi_out_reg.
`default_nettype none

module sd_spi_init_sequencer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [19:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_req_type,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_tx_byte,
    output logic             o_cs_low,
    output logic             o_finished,
    output logic [2:0]       o_status
);

    sdsi_pkg::t_cfg_wr cfg_wr;
    sdsi_pkg::t_result next_result;
    sdsi_pkg::t_result held_result;
    logic              accept;

    assign cfg_wr.we    = i_cfg_we;
    assign cfg_wr.index = i_cfg_index;
    assign cfg_wr.data  = i_cfg_data;

    assign accept = i_in_valid && o_in_ready;

    sdsi_seq_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg_wr),
        .i_accept   (accept),
        .i_req_type (i_req_type),
        .i_rx_byte  (i_rx_byte),
        .o_result   (next_result)
    );

    sdsi_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_result    (next_result),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_can_load  (o_in_ready),
        .o_result    (held_result)
    );

    assign o_tx_byte  = held_result.tx_byte;
    assign o_cs_low   = held_result.cs_low;
    assign o_finished = held_result.finished;
    assign o_status   = held_result.status;

endmodule

`default_nettype wire

@@ hw/rtl/sdsi_checker.sv @@
// Port-level checker for sd_spi_init_sequencer, attached by bind.
// Depends on sd_spi_init_sequencer_macros.svh and sdsi_pkg.
`default_nettype none
`include "sd_spi_init_sequencer_macros.svh"

module sdsi_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        i_req_type,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [7:0]  o_tx_byte,
    input wire logic        o_cs_low,
    input wire logic        o_finished,
    input wire logic [2:0]  o_status
);

    logic [12:0] out_word;
    logic        start_acc;
    logic        start_reply;

    assign out_word    = {o_tx_byte, o_cs_low, o_finished, o_status};
    assign start_acc   = i_in_valid && o_in_ready && !i_req_type;
    assign start_reply = o_out_valid && !o_cs_low && !o_finished
                         && (o_status == sdsi_pkg::ST_BUSY) && (o_tx_byte == 8'hFF);

    // stalled result transaction holds
    `SDSI_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(out_word))

    // a finished result never carries a command byte
    `SDSI_ASSERT_SAME(a_fin_idle_byte, o_out_valid && o_finished, o_tx_byte == 8'hFF)

    // any final status comes with finished set
    `SDSI_ASSERT_SAME(a_status_fin, o_out_valid && (o_status != sdsi_pkg::ST_BUSY), o_finished)

    // a start request yields a busy result with chip-select high
    `SDSI_ASSERT_NEXT(a_start_result, start_acc, start_reply)

endmodule

bind sd_spi_init_sequencer sdsi_checker u_sdsi_checker (.*);

`default_nettype wire
